/* src/mhpq_pkg.sv */
// Shared types and constants for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

    // Field widths
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 31;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    // Default heap capacity
    localparam int HEAP_DEPTH_DEF = 1024;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Input word
    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [KEY_W-1:0]       out_key;
        logic [VAL_W-1:0]       out_payload;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_item_t;

    // One heap slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] payload;
    } heap_entry_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START_INSERT,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_READ_ROOT,
        OP_TAKE_ROOT,
        OP_TAKE_LAST,
        OP_READ_PARENT,
        OP_MOVE_PARENT,
        OP_PLACE,
        OP_READ_LEFT,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT,
        OP_MOVE_CHILD,
        OP_PUBLISH
    } dp_op_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic parent_greater;
        logic no_child;
        logic left_is_last;
        logic sink;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/min_heap_priority_queue_unit.sv */
// Sequence, accept to result valid: a full or empty reject goes straight to the result; an insert
// climbs L levels (L at most log2 depth), each a heap memory read, compare and write, then places
// the entry. A remove takes the root and the last entry, then descends L levels, each a heap
// memory read, compare and write, and places the entry. The result waits for a free output slot.
// Throughput: one word at a time, taken the cycle after the previous result is registered.
// Reset: count cleared, heap memory not cleared.
`default_nettype none

module min_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload
);

    dp_op_t     op;
    dp_status_t status;

    // Sequencer
    mhpq_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_payload.command),
        .status    (status),
        .s_ready   (s_ready),
        .op        (op)
    );

    // Heap storage and result registers
    mhpq_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload),
        .status    (status)
    );

endmodule

`default_nettype wire

/* src/mhpq_datapath.sv */
// Datapath of the min-heap queue: heap memory, count, position and result registers.
`default_nettype none

module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_op_t     op,
    input  wire in_item_t   s_payload,
    input  wire logic       m_ready,
    output logic            m_valid,
    output out_item_t       m_payload,
    output dp_status_t      status
);

    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int POS_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(HEAP_DEPTH);

    // Heap storage, positions 1..count live at addresses 0..count-1
    heap_entry_t       mem [HEAP_DEPTH];
    heap_entry_t       rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  child_pos_reg;
    heap_entry_t       move_reg;
    heap_entry_t       child_reg;
    logic [STATUS_W-1:0] res_status_reg;
    heap_entry_t       res_entry_reg;
    logic              m_valid_reg;
    out_item_t         m_payload_reg;

    logic [POS_W-1:0]  count_ext;
    logic [POS_W-1:0]  pos_dec;
    logic [POS_W-1:0]  parent_pos;
    logic [POS_W-1:0]  parent_dec;
    logic [POS_W-1:0]  left_pos;
    logic [POS_W-1:0]  left_dec;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  count_inc;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    heap_entry_t       wr_data;

    // Position arithmetic
    assign count_ext  = {1'b0, count_reg};
    assign pos_dec    = pos_reg - POS_W'(1);
    assign parent_pos = pos_reg >> 1;
    assign parent_dec = parent_pos - POS_W'(1);
    assign left_pos   = {pos_reg[POS_W-2:0], 1'b0};
    assign left_dec   = left_pos - POS_W'(1);
    assign count_dec  = count_reg - CNT_W'(1);
    assign count_inc  = count_reg + CNT_W'(1);

    // Flags for the controller
    always_comb begin
        status.full           = (count_reg >= CNT_W'(HEAP_DEPTH));
        status.empty          = (count_reg == '0);
        status.at_root        = (pos_reg == POS_W'(1));
        status.parent_greater = (rd_data_reg.key > move_reg.key);
        status.no_child       = (left_pos > count_ext);
        status.left_is_last   = (left_pos == count_ext);
        status.sink           = (move_reg.key > child_reg.key);
        status.out_free       = !m_valid_reg || m_ready;
    end

    // Select memory read address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (op)
            OP_READ_ROOT: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_TAKE_ROOT: begin
                rd_en   = 1'b1;
                rd_addr = count_dec[ADDR_W-1:0];
            end
            OP_READ_PARENT: begin
                rd_en   = 1'b1;
                rd_addr = parent_dec[ADDR_W-1:0];
            end
            OP_READ_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = left_dec[ADDR_W-1:0];
            end
            OP_TAKE_LEFT: begin
                // right child sits at position 2*pos+1, address 2*pos
                rd_en   = !status.left_is_last;
                rd_addr = left_pos[ADDR_W-1:0];
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // Select memory write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_dec[ADDR_W-1:0];
        wr_data = move_reg;
        unique case (op)
            OP_MOVE_PARENT: begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
            end
            OP_MOVE_CHILD: begin
                wr_en   = 1'b1;
                wr_data = child_reg;
            end
            OP_PLACE: begin
                wr_en   = 1'b1;
                wr_data = move_reg;
            end
            default: begin
                wr_en   = 1'b0;
                wr_data = move_reg;
            end
        endcase
    end

    // Heap memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_START_INSERT: begin
                move_reg.key     <= s_payload.key;
                move_reg.payload <= s_payload.payload;
                pos_reg          <= {1'b0, count_inc};
                res_status_reg   <= STATUS_OK;
                res_entry_reg    <= '0;
            end
            OP_SET_FULL: begin
                res_status_reg <= STATUS_FULL;
                res_entry_reg  <= '0;
            end
            OP_SET_EMPTY: begin
                res_status_reg <= STATUS_EMPTY;
                res_entry_reg  <= '0;
            end
            OP_TAKE_ROOT: begin
                res_status_reg <= STATUS_OK;
                res_entry_reg  <= rd_data_reg;
            end
            OP_TAKE_LAST: begin
                move_reg <= rd_data_reg;
                pos_reg  <= POS_W'(1);
            end
            OP_MOVE_PARENT: begin
                pos_reg <= parent_pos;
            end
            OP_TAKE_LEFT: begin
                child_reg     <= rd_data_reg;
                child_pos_reg <= left_pos;
            end
            OP_TAKE_RIGHT: begin
                // take right child only when strictly smaller
                if (rd_data_reg.key < child_reg.key) begin
                    child_reg     <= rd_data_reg;
                    child_pos_reg <= {child_pos_reg[POS_W-1:1], 1'b1};
                end
            end
            OP_MOVE_CHILD: begin
                pos_reg <= child_pos_reg;
            end
            default: begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    // Fill count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (op == OP_START_INSERT) begin
                count_reg <= count_inc;
            end else if (op == OP_TAKE_LAST) begin
                count_reg <= count_dec;
            end
            if (op == OP_PUBLISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word, loaded when the slot is free
    always_ff @(posedge aclk) begin
        if (op == OP_PUBLISH) begin
            m_payload_reg.status      <= res_status_reg;
            m_payload_reg.out_key     <= res_entry_reg.key;
            m_payload_reg.out_payload <= res_entry_reg.payload;
            m_payload_reg.entry_count <= COUNT_OUT_W'(count_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

/* src/mhpq_controller.sv */
// Controller state machine that sequences inserts, removes and result hand-off.
`default_nettype none

module mhpq_controller
    import mhpq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_command,
    input  wire dp_status_t status,
    output logic            s_ready,
    output dp_op_t          op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHECK,
        ST_INS_CMP,
        ST_RM_ROOT,
        ST_RM_LAST,
        ST_DN_CHECK,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    // Next state and datapath operation
    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                // Start only on a word that is actually taken
                if (s_valid && s_ready_reg) begin
                    if (s_command == CMD_INSERT) begin
                        if (status.full) begin
                            op         = OP_SET_FULL;
                            state_next = ST_FINISH;
                        end else begin
                            op         = OP_START_INSERT;
                            state_next = ST_INS_CHECK;
                        end
                    end else if (status.empty) begin
                        op         = OP_SET_EMPTY;
                        state_next = ST_FINISH;
                    end else begin
                        op         = OP_READ_ROOT;
                        state_next = ST_RM_ROOT;
                    end
                end
            end
            // Sift up: climb while the parent key is strictly greater
            ST_INS_CHECK: begin
                if (status.at_root) begin
                    op         = OP_PLACE;
                    state_next = ST_FINISH;
                end else begin
                    op         = OP_READ_PARENT;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (status.parent_greater) begin
                    op         = OP_MOVE_PARENT;
                    state_next = ST_INS_CHECK;
                end else begin
                    op         = OP_PLACE;
                    state_next = ST_FINISH;
                end
            end
            // Remove: capture root, then fetch last entry
            ST_RM_ROOT: begin
                op         = OP_TAKE_ROOT;
                state_next = ST_RM_LAST;
            end
            ST_RM_LAST: begin
                op         = OP_TAKE_LAST;
                state_next = ST_DN_CHECK;
            end
            // Sift down one level at a time
            ST_DN_CHECK: begin
                if (status.no_child) begin
                    op         = OP_PLACE;
                    state_next = ST_FINISH;
                end else begin
                    op         = OP_READ_LEFT;
                    state_next = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT: begin
                op         = OP_TAKE_LEFT;
                state_next = status.left_is_last ? ST_DN_CMP : ST_DN_RIGHT;
            end
            ST_DN_RIGHT: begin
                op         = OP_TAKE_RIGHT;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (status.sink) begin
                    op         = OP_MOVE_CHILD;
                    state_next = ST_DN_CHECK;
                end else begin
                    op         = OP_PLACE;
                    state_next = ST_FINISH;
                end
            end
            // Hold the result until the output register is free
            ST_FINISH: begin
                if (status.out_free) begin
                    op         = OP_PUBLISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

/* src/mhpq_checker.sv */
// Port-level checker for the min-heap queue, bound to the top level.
`default_nettype none

module mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_payload,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_payload
);

    // One word in flight: ready drops after every accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // Rejects carry no entry
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.status == STATUS_EMPTY || m_payload.status == STATUS_FULL))
        |-> (m_payload.out_key == '0 && m_payload.out_payload == '0))
        else $error("rejected item returned an entry");

    // Empty reject only with zero count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STATUS_EMPTY) |-> (m_payload.entry_count == '0))
        else $error("empty status with nonzero count");

    // Count never passes capacity (checked for depths up to 2047)
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((HEAP_DEPTH > 2047) ||
                     (32'(m_payload.entry_count) <= 32'(HEAP_DEPTH))))
        else $error("entry count above capacity");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("result changed while stalled");

endmodule

bind min_heap_priority_queue_unit mhpq_checker #(
    .HEAP_DEPTH (HEAP_DEPTH)
) u_mhpq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
